[design/uart_idle_timeout_framer_unit_macros.svh]
// Assertion macros used by the idle-timeout framer core.
`ifndef UART_IDLE_TIMEOUT_FRAMER_UNIT_MACROS_SVH
`define UART_IDLE_TIMEOUT_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define UITF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define UITF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/uitf_pkg.sv]
// Package with the types and constants of the idle-timeout framer.
`timescale 1ns / 1ps
`default_nettype none

package uitf_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 256;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam logic [15:0] RESET_GAP_COORD = 16'd350;
    localparam logic [15:0] RESET_GAP_NODE = 16'd3500;
    localparam logic [7:0] HEADER_MASK = 8'h3F;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_READ    = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_COMPLETE = 3'd2,
        ST_NO_EVENT = 3'd3,
        ST_READ     = 3'd4,
        ST_RELEASED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_NODE_MODE  = 2'd0,
        REG_NODE_ID    = 2'd1,
        REG_GAP_COORD  = 2'd2,
        REG_GAP_NODE   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic        node_mode;
        logic [7:0]  node_id;
        logic [15:0] gap_coord;
        logic [15:0] gap_node;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  header_bits;
        logic        payload_start;
        logic        rd_from_ram;
        logic [7:0]  rd_value;
        logic        overflow;
    } result_t;

endpackage

`default_nettype wire

[design/uitf_ifs.sv]
// Valid/ready channel interfaces for the framer's item and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface uitf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    modport source (output valid, output operation, output rx_byte, output read_index,
                    input ready);
    modport sink (input valid, input operation, input rx_byte, input read_index,
                  output ready);
endinterface

interface uitf_rsp_if #(
    parameter int LEN_W = 9
);
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [LEN_W-1:0] frame_length;
    logic [5:0]       header_bits;
    logic             payload_start;
    logic [7:0]       read_value;
    logic             overflow;

    modport source (output valid, output status, output frame_length, output header_bits,
                    output payload_start, output read_value, output overflow,
                    input ready);
    modport sink (input valid, input status, input frame_length, input header_bits,
                  input payload_start, input read_value, input overflow,
                  output ready);
endinterface

`default_nettype wire

[design/uart_idle_timeout_framer_unit.sv]
// Top level of the serial receive framer closed by a silence timeout.
// An accepted item passes the input register, then the result register (with the buffer
// memory's registered read alongside it), before it gives its result beat.
// Throughput: one item per cycle unless a result waits; then the input register holds one beat.
// Reset clears counters, flags and the silence timer and sets the configuration registers to their reset values;
// the frame buffer memory is not cleared, and only entries written for a frame are read.
`timescale 1ns / 1ps
`default_nettype none

module uart_idle_timeout_framer_unit #(
    parameter int BUFFER_DEPTH = uitf_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [uitf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [uitf_pkg::CFG_DATA_W-1:0]  cfg_data,
    uitf_req_if.sink                              req,
    uitf_rsp_if.source                            rsp
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);

    uitf_pkg::cfg_t    cfg_reg;
    uitf_pkg::cfg_t    cfg_next;
    uitf_pkg::result_t result;
    logic              item_valid;
    logic [1:0]        item_op;
    logic [7:0]        item_byte;
    logic [7:0]        item_index;
    logic              advance;
    logic              out_busy;
    logic [CNT_W-1:0]  length;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (uitf_pkg::cfg_idx_t'(cfg_index))
                uitf_pkg::REG_NODE_MODE: cfg_next.node_mode = cfg_data[0];
                uitf_pkg::REG_NODE_ID:   cfg_next.node_id   = cfg_data[7:0];
                uitf_pkg::REG_GAP_COORD: cfg_next.gap_coord = cfg_data[15:0];
                uitf_pkg::REG_GAP_NODE:  cfg_next.gap_node  = cfg_data[15:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_mode <= 1'b0;
            cfg_reg.node_id   <= 8'd0;
            cfg_reg.gap_coord <= uitf_pkg::RESET_GAP_COORD;
            cfg_reg.gap_node  <= uitf_pkg::RESET_GAP_NODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign advance = item_valid && !out_busy;

    uitf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item_op    (item_op),
        .item_byte  (item_byte),
        .item_index (item_index)
    );

    uitf_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .CNT_W        (CNT_W),
        .AW           (AW)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .step       (advance),
        .item_op    (item_op),
        .item_byte  (item_byte),
        .item_index (item_index),
        .result     (result),
        .length     (length),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr)
    );

    uitf_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    uitf_out_stage #(
        .LEN_W (CNT_W)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .length    (length),
        .ram_rdata (ram_rdata),
        .busy      (out_busy),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

[design/uitf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module uitf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/uitf_in_stage.sv]
// Input register stage that captures one item beat and holds it until it advances.
`timescale 1ns / 1ps
`default_nettype none

module uitf_in_stage (
    input  wire logic    clk,
    input  wire logic    rst_n,
    uitf_req_if.sink     req,
    input  wire logic    advance,
    output      logic    item_valid,
    output      logic [1:0] item_op,
    output      logic [7:0] item_byte,
    output      logic [7:0] item_index
);

    logic       valid_reg;
    logic       valid_next;
    logic [1:0] op_reg;
    logic [7:0] byte_reg;
    logic [7:0] index_reg;
    logic       take;

    assign req.ready = !valid_reg || advance;
    assign take = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg    <= req.operation;
            byte_reg  <= req.rx_byte;
            index_reg <= req.read_index;
        end
    end

    assign item_valid = valid_reg;
    assign item_op    = op_reg;
    assign item_byte  = byte_reg;
    assign item_index = index_reg;

endmodule

`default_nettype wire

[design/uitf_core.sv]
// Framer state and the single-pass update that one item applies to it.
`timescale 1ns / 1ps
`default_nettype none

`include "uart_idle_timeout_framer_unit_macros.svh"

module uitf_core #(
    parameter int BUFFER_DEPTH = uitf_pkg::DEFAULT_BUFFER_DEPTH,
    parameter int CNT_W = $clog2(BUFFER_DEPTH + 1),
    parameter int AW = $clog2(BUFFER_DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire uitf_pkg::cfg_t   cfg,
    input  wire logic             step,
    input  wire logic [1:0]       item_op,
    input  wire logic [7:0]       item_byte,
    input  wire logic [7:0]       item_index,
    output      uitf_pkg::result_t result,
    output      logic [CNT_W-1:0] length,
    output      logic             ram_we,
    output      logic [AW-1:0]    ram_waddr,
    output      logic [7:0]       ram_wdata,
    output      logic             ram_re,
    output      logic [AW-1:0]    ram_raddr
);

    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int IDX_W = (AW > 8) ? AW : 8;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             receiving_reg;
    logic             receiving_next;
    logic [15:0]      timer_reg;
    logic [15:0]      timer_next;
    logic             held_reg;
    logic             held_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic [7:0]       first_reg;
    logic [7:0]       first_next;
    logic [IDX_W-1:0] index_ext;

    assign index_ext = IDX_W'(item_index);

    always_comb
    begin
        logic [15:0]      gap;
        logic [15:0]      timer_dec;
        logic [CNT_W-1:0] slot;
        logic             read_ok;

        count_next     = count_reg;
        receiving_next = receiving_reg;
        timer_next     = timer_reg;
        held_next      = held_reg;
        overflow_next  = overflow_reg;
        first_next     = first_reg;
        result         = '0;
        result.status  = uitf_pkg::ST_NO_EVENT;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = item_byte;
        ram_re         = 1'b0;
        ram_raddr      = index_ext[AW-1:0];
        gap            = cfg.node_mode ? cfg.gap_node : cfg.gap_coord;
        timer_dec      = timer_reg - 16'd1;
        slot           = count_reg;
        read_ok        = CMP_W'(item_index) < CMP_W'(count_reg);

        case (uitf_pkg::op_t'(item_op))
            uitf_pkg::OP_BYTE:
            begin
                if (held_reg)
                begin
                    result.status = uitf_pkg::ST_IGNORED;
                end
                else
                begin
                    timer_next     = (gap == 16'd0) ? 16'd1 : gap;
                    receiving_next = 1'b1;
                    if (!receiving_reg)
                    begin
                        overflow_next = 1'b0;
                        slot          = '0;
                        if (cfg.node_mode)
                        begin
                            first_next = cfg.node_id;
                            slot       = CNT_W'(1);
                        end
                    end
                    if (slot >= DEPTH_CNT)
                    begin
                        overflow_next = 1'b1;
                        count_next    = slot;
                        result.status = uitf_pkg::ST_IGNORED;
                    end
                    else
                    begin
                        count_next    = slot + CNT_W'(1);
                        result.status = uitf_pkg::ST_STORED;
                        if (slot == '0)
                        begin
                            first_next = item_byte;
                        end
                        else
                        begin
                            ram_we    = step;
                            ram_waddr = slot[AW-1:0];
                        end
                    end
                end
            end
            uitf_pkg::OP_TICK:
            begin
                if (timer_reg != 16'd0)
                begin
                    timer_next = timer_dec;
                    if (timer_dec == 16'd0)
                    begin
                        receiving_next = 1'b0;
                        if (count_reg != '0)
                        begin
                            held_next     = 1'b1;
                            result.status = uitf_pkg::ST_COMPLETE;
                        end
                    end
                end
            end
            uitf_pkg::OP_READ:
            begin
                result.status = uitf_pkg::ST_READ;
                if (read_ok)
                begin
                    if (item_index == 8'd0)
                    begin
                        result.rd_value = first_reg;
                    end
                    else
                    begin
                        result.rd_from_ram = 1'b1;
                        ram_re             = step;
                    end
                end
            end
            uitf_pkg::OP_RELEASE:
            begin
                result.status = uitf_pkg::ST_RELEASED;
                held_next     = 1'b0;
            end
            default:
            begin
                result.status = uitf_pkg::ST_NO_EVENT;
            end
        endcase

        result.payload_start = !cfg.node_mode;
        result.overflow      = overflow_next;
        if (!cfg.node_mode && count_next != '0)
        begin
            result.header_bits = 6'(first_next & uitf_pkg::HEADER_MASK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            receiving_reg <= 1'b0;
            timer_reg     <= 16'd0;
            held_reg      <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else if (step)
        begin
            count_reg     <= count_next;
            receiving_reg <= receiving_next;
            timer_reg     <= timer_next;
            held_reg      <= held_next;
            overflow_reg  <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            first_reg <= first_next;
        end
    end

    assign length = count_next;

    `UITF_ASSERT_NOW(a_count_max, 1'b1, count_reg <= DEPTH_CNT, "byte count beyond buffer depth")
    `UITF_ASSERT_NOW(a_held_idle, held_reg, !receiving_reg, "frame held while receiving")
    `UITF_ASSERT_NOW(a_ovf_full, overflow_reg, count_reg == DEPTH_CNT, "overflow with room left")
    `UITF_ASSERT_NOW(a_rx_timer, receiving_reg, timer_reg != 16'd0, "receiving with timer stopped")

endmodule

`default_nettype wire

[design/uitf_out_stage.sv]
// Result register that presents one result beat and holds it until taken.
`timescale 1ns / 1ps
`default_nettype none

module uitf_out_stage #(
    parameter int LEN_W = 9
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire uitf_pkg::result_t result,
    input  wire logic [LEN_W-1:0]  length,
    input  wire logic [7:0]        ram_rdata,
    output      logic              busy,
    uitf_rsp_if.source             rsp
);

    logic              valid_reg;
    logic              valid_next;
    uitf_pkg::result_t result_reg;
    logic [LEN_W-1:0]  length_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
            length_reg <= length;
        end
    end

    assign busy              = valid_reg && !rsp.ready;
    assign rsp.valid         = valid_reg;
    assign rsp.status        = result_reg.status;
    assign rsp.frame_length  = length_reg;
    assign rsp.header_bits   = result_reg.header_bits;
    assign rsp.payload_start = result_reg.payload_start;
    assign rsp.read_value    = result_reg.rd_from_ram ? ram_rdata : result_reg.rd_value;
    assign rsp.overflow      = result_reg.overflow;

endmodule

`default_nettype wire
